[rtl/core/assert_macros.svh]
// Assertion macros for the rtl/core blocks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// expr must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("assertion failed");

// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rstn, expr)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

[rtl/core/qrm_pkg.sv]
package qrm_pkg;

    localparam int FRAC_BITS_IN_DEF  = 20;
    localparam int FRAC_BITS_OUT_DEF = 22;
    localparam int IO_W              = 24;
    localparam int NUM_ENTRIES       = 9;
    localparam int NUM_QUOT          = 6;

    // quotient slots of the renormalising dividers
    localparam int Q_D0 = 0;
    localparam int Q_AB = 1;
    localparam int Q_AC = 2;
    localparam int Q_D4 = 3;
    localparam int Q_BC = 4;
    localparam int Q_D8 = 5;

    typedef struct packed {
        logic valid;
        logic ren;
    } ctl_t;

endpackage

[rtl/core/qrm_in_if.sv]
interface qrm_in_if;

    logic                              valid;
    logic                              ready;
    logic signed [qrm_pkg::IO_W-1:0]   q_first;
    logic signed [qrm_pkg::IO_W-1:0]   q_second;
    logic signed [qrm_pkg::IO_W-1:0]   q_third;

    modport source (output valid, output q_first, output q_second, output q_third,
                    input ready);
    modport sink   (input valid, input q_first, input q_second, input q_third,
                    output ready);

endinterface

[rtl/core/qrm_out_if.sv]
interface qrm_out_if;

    logic                              valid;
    logic                              ready;
    logic signed [qrm_pkg::IO_W-1:0]   m_r0c0;
    logic signed [qrm_pkg::IO_W-1:0]   m_r0c1;
    logic signed [qrm_pkg::IO_W-1:0]   m_r0c2;
    logic signed [qrm_pkg::IO_W-1:0]   m_r1c0;
    logic signed [qrm_pkg::IO_W-1:0]   m_r1c1;
    logic signed [qrm_pkg::IO_W-1:0]   m_r1c2;
    logic signed [qrm_pkg::IO_W-1:0]   m_r2c0;
    logic signed [qrm_pkg::IO_W-1:0]   m_r2c1;
    logic signed [qrm_pkg::IO_W-1:0]   m_r2c2;
    logic                              renormalized;

    modport source (output valid, output m_r0c0, output m_r0c1, output m_r0c2,
                    output m_r1c0, output m_r1c1, output m_r1c2, output m_r2c0,
                    output m_r2c1, output m_r2c2, output renormalized, input ready);
    modport sink   (input valid, input m_r0c0, input m_r0c1, input m_r0c2,
                    input m_r1c0, input m_r1c1, input m_r1c2, input m_r2c0,
                    input m_r2c1, input m_r2c2, input renormalized, output ready);

endinterface

[rtl/core/qrm_front.sv]
module qrm_front #(
    parameter int FRAC_BITS_IN = qrm_pkg::FRAC_BITS_IN_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   adv,
    input  logic                                   in_valid,
    input  logic signed [qrm_pkg::IO_W-1:0]        q_first,
    input  logic signed [qrm_pkg::IO_W-1:0]        q_second,
    input  logic signed [qrm_pkg::IO_W-1:0]        q_third,
    output qrm_pkg::ctl_t                          ctl_out,
    output logic [2*FRAC_BITS_IN+1:0]              v_out,
    output logic [qrm_pkg::NUM_QUOT-1:0][2*FRAC_BITS_IN+3:0] x_out,
    output logic [qrm_pkg::NUM_QUOT-1:0]           neg_out,
    output logic [2*FRAC_BITS_IN+3:0]              d_out,
    output logic [3*((FRAC_BITS_IN+2 > qrm_pkg::IO_W) ? FRAC_BITS_IN+2 : qrm_pkg::IO_W)
                  + 6*(2*FRAC_BITS_IN+4)-1:0]      carry_out
);

    localparam int F  = FRAC_BITS_IN;
    localparam int AW = (F + 2 > qrm_pkg::IO_W) ? F + 2 : qrm_pkg::IO_W;
    localparam int EW = ((F > qrm_pkg::IO_W - 1) ? F : qrm_pkg::IO_W - 1) + 3;
    localparam int PW = 2 * F + 4;
    localparam int VW = 2 * F + 2;
    localparam int DW = 2 * F + 4;
    localparam int NQ = qrm_pkg::NUM_QUOT;

    localparam logic signed [EW-1:0] ONE_E = EW'(1) << F;
    localparam logic signed [EW-1:0] PM    = (EW'(1) << (F + 1)) - EW'(1);
    localparam logic signed [PW-1:0] ONE2  = PW'(1) << (2 * F);

    function automatic logic signed [AW-1:0] wrap(input logic signed [qrm_pkg::IO_W-1:0] q);
        logic signed [EW-1:0] qe;
        logic signed [EW-1:0] r;
        qe = EW'(q);
        if (qe > ONE_E)
            r = ((qe + ONE_E) & PM) - ONE_E;
        else if (qe < -ONE_E)
            r = ONE_E - ((ONE_E - qe) & PM);
        else
            r = qe;
        return r[AW-1:0];
    endfunction

    function automatic logic signed [PW-1:0] mul(input logic signed [AW-1:0] x,
                                                 input logic signed [AW-1:0] y);
        logic signed [2*AW-1:0] p;
        p = x * y;
        return p[PW-1:0];
    endfunction

    logic                   va_reg, vb_reg, vc_reg;
    qrm_pkg::ctl_t          ctl_reg, ctl_next;

    logic signed [AW-1:0]   a_reg, b_reg, c_reg;
    logic signed [AW-1:0]   ab_a_reg, ab_b_reg, ab_c_reg;
    logic signed [AW-1:0]   ac_a_reg, ac_b_reg, ac_c_reg;
    logic signed [PW-1:0]   sa_reg, sb_reg, sc_reg, pab_reg, pac_reg, pbc_reg;
    logic signed [PW-1:0]   s_reg, cab_reg, cac_reg, cbc_reg, d0_reg, d4_reg, d8_reg;
    logic signed [PW-1:0]   n_reg [NQ];

    logic signed [PW-1:0]   w2_full;
    logic [VW-1:0]          v_next;
    logic [NQ-1:0][DW-1:0]  x_next;
    logic [NQ-1:0]          neg_next;
    logic signed [PW-1:0]   nabs;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg  <= 1'b0;
            vb_reg  <= 1'b0;
            vc_reg  <= 1'b0;
            ctl_reg <= '0;
        end
        else if (adv)
        begin
            va_reg  <= in_valid;
            vb_reg  <= va_reg;
            vc_reg  <= vb_reg;
            ctl_reg <= ctl_next;
        end
    end

    always_comb
    begin
        ctl_next.valid = vc_reg;
        ctl_next.ren   = vc_reg && (s_reg > ONE2);
        w2_full = ONE2 - s_reg;
        v_next  = ctl_next.ren ? '0 : w2_full[VW-1:0];
        for (int k = 0; k < NQ; k++)
        begin
            nabs        = n_reg[k][PW-1] ? -n_reg[k] : n_reg[k];
            x_next[k]   = nabs[DW-1:0];
            neg_next[k] = n_reg[k][PW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // wrap
            a_reg <= wrap(q_first);
            b_reg <= wrap(q_second);
            c_reg <= wrap(q_third);
            // products
            sa_reg   <= mul(a_reg, a_reg);
            sb_reg   <= mul(b_reg, b_reg);
            sc_reg   <= mul(c_reg, c_reg);
            pab_reg  <= mul(a_reg, b_reg);
            pac_reg  <= mul(a_reg, c_reg);
            pbc_reg  <= mul(b_reg, c_reg);
            ab_a_reg <= a_reg;
            ab_b_reg <= b_reg;
            ab_c_reg <= c_reg;
            // sums
            s_reg   <= sa_reg + sb_reg + sc_reg;
            n_reg[qrm_pkg::Q_D0] <= sa_reg - sb_reg - sc_reg;
            n_reg[qrm_pkg::Q_AB] <= pab_reg + pab_reg;
            n_reg[qrm_pkg::Q_AC] <= pac_reg + pac_reg;
            n_reg[qrm_pkg::Q_D4] <= sb_reg - sa_reg - sc_reg;
            n_reg[qrm_pkg::Q_BC] <= pbc_reg + pbc_reg;
            n_reg[qrm_pkg::Q_D8] <= sc_reg - sa_reg - sb_reg;
            d0_reg  <= ONE2 - (sb_reg + sb_reg) - (sc_reg + sc_reg);
            d4_reg  <= ONE2 - (sa_reg + sa_reg) - (sc_reg + sc_reg);
            d8_reg  <= ONE2 - (sa_reg + sa_reg) - (sb_reg + sb_reg);
            cab_reg <= pab_reg;
            cac_reg <= pac_reg;
            cbc_reg <= pbc_reg;
            ac_a_reg <= ab_a_reg;
            ac_b_reg <= ab_b_reg;
            ac_c_reg <= ab_c_reg;
            // split to square root / dividers
            v_out     <= v_next;
            x_out     <= x_next;
            neg_out   <= neg_next;
            d_out     <= s_reg[DW-1:0];
            carry_out <= {ac_a_reg, ac_b_reg, ac_c_reg, cab_reg, cac_reg, cbc_reg,
                          d0_reg, d4_reg, d8_reg};
        end
    end

    assign ctl_out = ctl_reg;

endmodule

[rtl/core/qrm_iter.sv]
module qrm_iter #(
    parameter int FRAC_BITS_IN  = qrm_pkg::FRAC_BITS_IN_DEF,
    parameter int FRAC_BITS_OUT = qrm_pkg::FRAC_BITS_OUT_DEF,
    parameter int IDX           = 0,
    parameter int CW            = 1
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic                                              adv,
    input  qrm_pkg::ctl_t                                     ctl_in,
    input  logic [2*FRAC_BITS_IN+1:0]                         v_in,
    input  logic [2*FRAC_BITS_IN+1:0]                         res_in,
    input  logic [qrm_pkg::NUM_QUOT-1:0][2*FRAC_BITS_IN+3:0]  x_in,
    input  logic [qrm_pkg::NUM_QUOT-1:0][FRAC_BITS_OUT+2:0]   quo_in,
    input  logic [qrm_pkg::NUM_QUOT-1:0]                      neg_in,
    input  logic [2*FRAC_BITS_IN+3:0]                         d_in,
    input  logic [CW-1:0]                                     carry_in,
    output qrm_pkg::ctl_t                                     ctl_out,
    output logic [2*FRAC_BITS_IN+1:0]                         v_out,
    output logic [2*FRAC_BITS_IN+1:0]                         res_out,
    output logic [qrm_pkg::NUM_QUOT-1:0][2*FRAC_BITS_IN+3:0]  x_out,
    output logic [qrm_pkg::NUM_QUOT-1:0][FRAC_BITS_OUT+2:0]   quo_out,
    output logic [qrm_pkg::NUM_QUOT-1:0]                      neg_out,
    output logic [2*FRAC_BITS_IN+3:0]                         d_out,
    output logic [CW-1:0]                                     carry_out
);

    localparam int F      = FRAC_BITS_IN;
    localparam int VW     = 2 * F + 2;
    localparam int DW     = 2 * F + 4;
    localparam int QB     = FRAC_BITS_OUT + 3;
    localparam int NQ     = qrm_pkg::NUM_QUOT;
    localparam bit DO_SQ  = (IDX <= F);
    localparam bit DO_DIV = (IDX < QB);
    localparam bit FIRST  = (IDX == 0);
    localparam int SQ_SH  = DO_SQ ? 2 * (F - IDX) : 0;
    localparam logic [VW-1:0] SQ_BIT = VW'(1) << SQ_SH;

    qrm_pkg::ctl_t          ctl_reg;
    logic [VW-1:0]          v_next, res_next, trial;
    logic [NQ-1:0][DW-1:0]  x_next;
    logic [NQ-1:0][QB-1:0]  quo_next;
    logic [DW-1:0]          xs, d2;

    always_comb
    begin
        v_next   = v_in;
        res_next = res_in;
        trial    = res_in + SQ_BIT;
        if (DO_SQ)
        begin
            if (v_in >= trial)
            begin
                v_next   = v_in - trial;
                res_next = (res_in >> 1) + SQ_BIT;
            end
            else
            begin
                res_next = res_in >> 1;
            end
        end
        d2       = d_in << 1;
        x_next   = x_in;
        quo_next = quo_in;
        for (int k = 0; k < NQ; k++)
        begin
            xs = FIRST ? x_in[k] : (x_in[k] << 1);
            if (DO_DIV)
            begin
                if (xs >= d2)
                begin
                    x_next[k]   = xs - d2;
                    quo_next[k] = {quo_in[k][QB-2:0], 1'b1};
                end
                else
                begin
                    x_next[k]   = xs;
                    quo_next[k] = {quo_in[k][QB-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else if (adv)
            ctl_reg <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            v_out     <= v_next;
            res_out   <= res_next;
            x_out     <= x_next;
            quo_out   <= quo_next;
            neg_out   <= neg_in;
            d_out     <= d_in;
            carry_out <= carry_in;
        end
    end

    assign ctl_out = ctl_reg;

endmodule

[rtl/core/qrm_back.sv]
module qrm_back #(
    parameter int FRAC_BITS_IN  = qrm_pkg::FRAC_BITS_IN_DEF,
    parameter int FRAC_BITS_OUT = qrm_pkg::FRAC_BITS_OUT_DEF,
    parameter int CW            = 1
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic                                              adv,
    input  qrm_pkg::ctl_t                                     ctl_in,
    input  logic [2*FRAC_BITS_IN+1:0]                         res_in,
    input  logic [qrm_pkg::NUM_QUOT-1:0][FRAC_BITS_OUT+2:0]   quo_in,
    input  logic [qrm_pkg::NUM_QUOT-1:0]                      neg_in,
    input  logic [CW-1:0]                                     carry_in,
    output logic                                              out_valid,
    output logic [qrm_pkg::NUM_ENTRIES-1:0][qrm_pkg::IO_W-1:0] m_out,
    output logic                                              ren_out
);

    localparam int F   = FRAC_BITS_IN;
    localparam int FO  = FRAC_BITS_OUT;
    localparam int AW  = (F + 2 > qrm_pkg::IO_W) ? F + 2 : qrm_pkg::IO_W;
    localparam int PW  = 2 * F + 4;
    localparam int QB  = FO + 3;
    localparam int NQ  = qrm_pkg::NUM_QUOT;
    localparam int NE  = qrm_pkg::NUM_ENTRIES;
    localparam int SH  = 2 * F - FO;
    localparam int PSH = (SH > 0) ? SH : 0;
    localparam int NSH = (SH < 0) ? -SH : 0;
    localparam int RH  = (SH > 0) ? SH - 1 : 0;
    localparam int RW  = PW + 1 + NSH;
    localparam int SW  = (FO + 2 > qrm_pkg::IO_W) ? FO + 2 : qrm_pkg::IO_W;
    localparam logic [RW-1:0] HALF  = (SH > 0) ? (RW'(1) << RH) : '0;
    localparam logic [FO:0]   ONE_O = (FO + 1)'(1) << FO;
    localparam int RMAP [NE] = '{qrm_pkg::Q_D0, qrm_pkg::Q_AB, qrm_pkg::Q_AC,
                                 qrm_pkg::Q_AB, qrm_pkg::Q_D4, qrm_pkg::Q_BC,
                                 qrm_pkg::Q_AC, qrm_pkg::Q_BC, qrm_pkg::Q_D8};

    function automatic logic signed [PW-1:0] mulw(input logic signed [F+1:0] w,
                                                  input logic signed [AW-1:0] x);
        logic signed [F+AW+1:0] p;
        p = w * x;
        return p[PW-1:0];
    endfunction

    logic signed [AW-1:0]  a_in, b_in, c_in;
    logic signed [PW-1:0]  ab_in, ac_in, bc_in, d0_in, d4_in, d8_in;
    logic signed [F+1:0]   ws;

    qrm_pkg::ctl_t         ctl_e_reg, ctl_f_reg, ctl_g_reg, ctl_h_reg;

    logic signed [PW-1:0]  wa_reg, wb_reg, wc_reg;
    logic signed [PW-1:0]  ab_e_reg, ac_e_reg, bc_e_reg, d0_e_reg, d4_e_reg, d8_e_reg;
    logic [QB-1:0]         rq_reg [NQ];
    logic [NQ-1:0]         neg_e_reg, neg_f_reg;
    logic signed [PW-1:0]  e_reg [NE];
    logic [FO:0]           rs_reg [NQ];
    logic [PW-1:0]         emag_reg [NE];
    logic [NE-1:0]         eneg_reg, rneg_reg;
    logic [FO:0]           rmag_reg [NE];
    logic [NE-1:0][qrm_pkg::IO_W-1:0] m_next, m_reg;

    logic [QB-1:0]         rq_next [NQ];
    logic [FO:0]           rs_next [NQ];
    logic [RW-1:0]         t;
    logic [FO:0]           mag;
    logic signed [SW-1:0]  val;

    assign {a_in, b_in, c_in, ab_in, ac_in, bc_in, d0_in, d4_in, d8_in} = carry_in;
    assign ws = {1'b0, res_in[F:0]};

    always_comb
    begin
        for (int k = 0; k < NQ; k++)
        begin
            rq_next[k] = (quo_in[k] + QB'(1)) >> 1;
            rs_next[k] = (rq_reg[k] > QB'(ONE_O)) ? ONE_O : rq_reg[k][FO:0];
        end
        for (int k = 0; k < NE; k++)
        begin
            if (SH > 0)
                t = (RW'(emag_reg[k]) + HALF) >> PSH;
            else
                t = RW'(emag_reg[k]) << NSH;
            if (ctl_g_reg.ren)
                mag = rmag_reg[k];
            else if (t > RW'(ONE_O))
                mag = ONE_O;
            else
                mag = t[FO:0];
            val = (ctl_g_reg.ren ? rneg_reg[k] : eneg_reg[k]) ? -SW'(mag) : SW'(mag);
            m_next[k] = val[qrm_pkg::IO_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_e_reg <= '0;
            ctl_f_reg <= '0;
            ctl_g_reg <= '0;
            ctl_h_reg <= '0;
        end
        else if (adv)
        begin
            ctl_e_reg <= ctl_in;
            ctl_f_reg <= ctl_e_reg;
            ctl_g_reg <= ctl_f_reg;
            ctl_h_reg <= ctl_g_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // scalar part products
            wa_reg    <= mulw(ws, a_in);
            wb_reg    <= mulw(ws, b_in);
            wc_reg    <= mulw(ws, c_in);
            ab_e_reg  <= ab_in;
            ac_e_reg  <= ac_in;
            bc_e_reg  <= bc_in;
            d0_e_reg  <= d0_in;
            d4_e_reg  <= d4_in;
            d8_e_reg  <= d8_in;
            rq_reg    <= rq_next;
            neg_e_reg <= neg_in;
            // entries
            e_reg[0]  <= d0_e_reg;
            e_reg[1]  <= (ab_e_reg + wc_reg) <<< 1;
            e_reg[2]  <= (ac_e_reg - wb_reg) <<< 1;
            e_reg[3]  <= (ab_e_reg - wc_reg) <<< 1;
            e_reg[4]  <= d4_e_reg;
            e_reg[5]  <= (bc_e_reg + wa_reg) <<< 1;
            e_reg[6]  <= (ac_e_reg + wb_reg) <<< 1;
            e_reg[7]  <= (bc_e_reg - wa_reg) <<< 1;
            e_reg[8]  <= d8_e_reg;
            rs_reg    <= rs_next;
            neg_f_reg <= neg_e_reg;
            // magnitudes
            for (int k = 0; k < NE; k++)
            begin
                emag_reg[k] <= e_reg[k][PW-1] ? -e_reg[k] : e_reg[k];
                eneg_reg[k] <= e_reg[k][PW-1];
                rmag_reg[k] <= rs_reg[RMAP[k]];
                rneg_reg[k] <= neg_f_reg[RMAP[k]];
            end
            // round, saturate, select
            m_reg <= m_next;
        end
    end

    assign out_valid = ctl_h_reg.valid;
    assign ren_out   = ctl_h_reg.ren;
    assign m_out     = m_reg;

endmodule

[rtl/core/quaternion_to_rotation_matrix.sv]
// Quaternion to 3x3 rotation matrix.
// Channel quat (sink) takes the three vector elements of a unit quaternion,
// signed Q3.20 by default; channel matrix (source) gives the nine entries in
// row-major order, signed Q1.22, saturated to +-1, plus the renormalized flag.
// Both channels move one item at a valid/ready edge.
// Elements beyond +-1 are wrapped with period 2. A sum of squares above one
// rescales the elements through six restoring dividers; otherwise the scalar
// part comes from a bit-serial square root, one result bit per stage.
// The pipeline length is set by the divider stages (one quotient bit each) at
// the default widths, where they outnumber the square root stages.
// Throughput: one item per cycle while the receiver is not stalling.
// Reset clears every valid bit; no results are pending afterwards.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and quat.ready drops; nothing is lost or repeated, and items keep flowing
// while the output register is free or being taken.
`include "assert_macros.svh"

module quaternion_to_rotation_matrix #(
    parameter int FRAC_BITS_IN  = qrm_pkg::FRAC_BITS_IN_DEF,
    parameter int FRAC_BITS_OUT = qrm_pkg::FRAC_BITS_OUT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    qrm_in_if.sink      quat,
    qrm_out_if.source   matrix
);

    localparam int F   = FRAC_BITS_IN;
    localparam int FO  = FRAC_BITS_OUT;
    localparam int AW  = (F + 2 > qrm_pkg::IO_W) ? F + 2 : qrm_pkg::IO_W;
    localparam int PW  = 2 * F + 4;
    localparam int VW  = 2 * F + 2;
    localparam int DW  = 2 * F + 4;
    localparam int QB  = FO + 3;
    localparam int CW  = 3 * AW + 6 * PW;
    localparam int NI  = (F + 1 > QB) ? F + 1 : QB;
    localparam int NQ  = qrm_pkg::NUM_QUOT;
    localparam int MID = NI / 2;

    logic                  adv;
    logic                  out_valid;
    logic                  ren;
    logic [qrm_pkg::NUM_ENTRIES-1:0][qrm_pkg::IO_W-1:0] m;

    qrm_pkg::ctl_t         ctl_c   [NI+1];
    logic [VW-1:0]         v_c     [NI+1];
    logic [VW-1:0]         res_c   [NI+1];
    logic [NQ-1:0][DW-1:0] x_c     [NI+1];
    logic [NQ-1:0][QB-1:0] quo_c   [NI+1];
    logic [NQ-1:0]         neg_c   [NI+1];
    logic [DW-1:0]         d_c     [NI+1];
    logic [CW-1:0]         carry_c [NI+1];

    assign adv        = !out_valid || matrix.ready;
    assign quat.ready = adv;
    assign res_c[0]   = '0;
    assign quo_c[0]   = '0;

    qrm_front #(
        .FRAC_BITS_IN (F)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (quat.valid),
        .q_first   (quat.q_first),
        .q_second  (quat.q_second),
        .q_third   (quat.q_third),
        .ctl_out   (ctl_c[0]),
        .v_out     (v_c[0]),
        .x_out     (x_c[0]),
        .neg_out   (neg_c[0]),
        .d_out     (d_c[0]),
        .carry_out (carry_c[0])
    );

    for (genvar i = 0; i < NI; i++)
    begin : g_iter
        qrm_iter #(
            .FRAC_BITS_IN  (F),
            .FRAC_BITS_OUT (FO),
            .IDX           (i),
            .CW            (CW)
        ) u_iter (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .ctl_in    (ctl_c[i]),
            .v_in      (v_c[i]),
            .res_in    (res_c[i]),
            .x_in      (x_c[i]),
            .quo_in    (quo_c[i]),
            .neg_in    (neg_c[i]),
            .d_in      (d_c[i]),
            .carry_in  (carry_c[i]),
            .ctl_out   (ctl_c[i+1]),
            .v_out     (v_c[i+1]),
            .res_out   (res_c[i+1]),
            .x_out     (x_c[i+1]),
            .quo_out   (quo_c[i+1]),
            .neg_out   (neg_c[i+1]),
            .d_out     (d_c[i+1]),
            .carry_out (carry_c[i+1])
        );
    end

    qrm_back #(
        .FRAC_BITS_IN  (F),
        .FRAC_BITS_OUT (FO),
        .CW            (CW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .ctl_in    (ctl_c[NI]),
        .res_in    (res_c[NI]),
        .quo_in    (quo_c[NI]),
        .neg_in    (neg_c[NI]),
        .carry_in  (carry_c[NI]),
        .out_valid (out_valid),
        .m_out     (m),
        .ren_out   (ren)
    );

    assign matrix.valid        = out_valid;
    assign matrix.m_r0c0       = m[0];
    assign matrix.m_r0c1       = m[1];
    assign matrix.m_r0c2       = m[2];
    assign matrix.m_r1c0       = m[3];
    assign matrix.m_r1c1       = m[4];
    assign matrix.m_r1c2       = m[5];
    assign matrix.m_r2c0       = m[6];
    assign matrix.m_r2c1       = m[7];
    assign matrix.m_r2c2       = m[8];
    assign matrix.renormalized = ren;

    `ASSERT_ALWAYS(a_full_blocks_input, clk, rst_n, !(matrix.valid && !matrix.ready) || !quat.ready)
    `ASSERT_NEXT(a_stall_holds_mid, clk, rst_n, !adv, $stable(ctl_c[MID]))
    `ASSERT_NEXT(a_valid_moves, clk, rst_n, adv && ctl_c[0].valid, ctl_c[1].valid)
    `ASSERT_ALWAYS(a_ren_only_valid, clk, rst_n, !ctl_c[NI].ren || ctl_c[NI].valid)

endmodule

[sim/qrm_checker.sv]
`timescale 1ns / 1ps

module qrm_checker #(
    parameter int FRAC_BITS_IN  = qrm_pkg::FRAC_BITS_IN_DEF,
    parameter int FRAC_BITS_OUT = qrm_pkg::FRAC_BITS_OUT_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    qrm_in_if     quat,
    qrm_out_if    matrix,
    output int    fail_count,
    output int    pending,
    output int    renorm_seen,
    output int    mats_seen
);

    typedef struct packed {
        logic [qrm_pkg::NUM_ENTRIES-1:0][qrm_pkg::IO_W-1:0] ent;
        logic                                               ren;
    } rot_t;

    rot_t rot_queue[$];

    function automatic longint sext24(logic [qrm_pkg::IO_W-1:0] v);
        return longint'($signed(v));
    endfunction

    function automatic longint wrap_elem(longint q);
        longint one;
        longint pm;
        one = longint'(1) << FRAC_BITS_IN;
        pm  = (longint'(2) << FRAC_BITS_IN) - 1;
        if (q > one)
            return ((q + one) & pm) - one;
        if (q < -one)
            return one - ((one - q) & pm);
        return q;
    endfunction

    function automatic longint int_sqrt(longint v);
        longint res;
        longint b;
        res = 0;
        b = longint'(1) << 62;
        while (b > v)
            b = b >>> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >>> 1) + b;
            end
            else
                res = res >>> 1;
            b = b >>> 2;
        end
        return res;
    endfunction

    function automatic longint clamp_one(longint v);
        longint one;
        one = longint'(1) << FRAC_BITS_OUT;
        if (v > one)
            return one;
        if (v < -one)
            return -one;
        return v;
    endfunction

    function automatic longint shift_round(longint v);
        int     sh;
        logic   neg;
        longint mag;
        sh  = 2 * FRAC_BITS_IN - FRAC_BITS_OUT;
        neg = v < 0;
        mag = neg ? -v : v;
        if (sh > 0)
            mag = (mag + (longint'(1) << (sh - 1))) >>> sh;
        else if (sh < 0)
            mag = mag << (-sh);
        return clamp_one(neg ? -mag : mag);
    endfunction

    function automatic longint div_round(longint n, longint d);
        logic   neg;
        longint mag;
        longint quo;
        longint rem;
        neg = n < 0;
        mag = neg ? -n : n;
        quo = mag / d;
        rem = mag % d;
        for (int i = 0; i < FRAC_BITS_OUT + 1; i++)
        begin
            rem = rem << 1;
            quo = quo << 1;
            if (rem >= d)
            begin
                rem = rem - d;
                quo = quo | 1;
            end
        end
        quo = (quo + 1) >>> 1;
        return clamp_one(neg ? -quo : quo);
    endfunction

    function automatic rot_t predict_rotation(logic [qrm_pkg::IO_W-1:0] x,
                                              logic [qrm_pkg::IO_W-1:0] y,
                                              logic [qrm_pkg::IO_W-1:0] z);
        longint a, b, c, sa, sb, sc, ab, ac, bc, s, one2, w2, w;
        longint m[qrm_pkg::NUM_ENTRIES];
        rot_t   r;
        a = wrap_elem(sext24(x));
        b = wrap_elem(sext24(y));
        c = wrap_elem(sext24(z));
        one2 = longint'(1) << (2 * FRAC_BITS_IN);
        sa = a * a; sb = b * b; sc = c * c;
        ab = a * b; ac = a * c; bc = b * c;
        s = sa + sb + sc;
        r.ren = s > one2;
        if (!r.ren)
        begin
            w2 = one2 - s;
            w  = int_sqrt(w2);
            m[0] = shift_round(w2 + sa - sb - sc);
            m[1] = shift_round(2 * (ab + w * c));
            m[2] = shift_round(2 * (ac - w * b));
            m[3] = shift_round(2 * (ab - w * c));
            m[4] = shift_round(w2 - sa + sb - sc);
            m[5] = shift_round(2 * (bc + w * a));
            m[6] = shift_round(2 * (ac + w * b));
            m[7] = shift_round(2 * (bc - w * a));
            m[8] = shift_round(w2 - sa - sb + sc);
        end
        else
        begin
            m[0] = div_round(sa - sb - sc, s);
            m[1] = div_round(2 * ab, s);
            m[2] = div_round(2 * ac, s);
            m[3] = m[1];
            m[4] = div_round(-sa + sb - sc, s);
            m[5] = div_round(2 * bc, s);
            m[6] = m[2];
            m[7] = m[5];
            m[8] = div_round(-sa - sb + sc, s);
        end
        for (int i = 0; i < qrm_pkg::NUM_ENTRIES; i++)
            r.ent[i] = m[i][qrm_pkg::IO_W-1:0];
        return r;
    endfunction

    string ent_name[qrm_pkg::NUM_ENTRIES] = '{"m_r0c0", "m_r0c1", "m_r0c2", "m_r1c0",
                                              "m_r1c1", "m_r1c2", "m_r2c0", "m_r2c1",
                                              "m_r2c2"};

    assign pending = rot_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        rot_t got;
        rot_t exp_rot;
        if (!rst_n)
        begin
            fail_count  <= 0;
            renorm_seen <= 0;
            mats_seen   <= 0;
            rot_queue.delete();
        end
        else
        begin
            if (quat.valid && quat.ready)
                rot_queue.insert(rot_queue.size(),
                                 predict_rotation(quat.q_first, quat.q_second,
                                                  quat.q_third));
            if (matrix.valid && matrix.ready)
            begin
                got.ent = {matrix.m_r2c2, matrix.m_r2c1, matrix.m_r2c0,
                           matrix.m_r1c2, matrix.m_r1c1, matrix.m_r1c0,
                           matrix.m_r0c2, matrix.m_r0c1, matrix.m_r0c0};
                got.ren = matrix.renormalized;
                mats_seen   <= mats_seen + 1;
                renorm_seen <= renorm_seen + got.ren;
                if (rot_queue.size() == 0)
                begin
                    $error("matrix item with nothing expected");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    int bad;
                    bad = 0;
                    exp_rot = rot_queue.pop_front();
                    for (int i = 0; i < qrm_pkg::NUM_ENTRIES; i++)
                        if (got.ent[i] !== exp_rot.ent[i])
                        begin
                            $error("%s: expected %0d, got %0d", ent_name[i],
                                   $signed(exp_rot.ent[i]), $signed(got.ent[i]));
                            bad = 1;
                        end
                    if (got.ren !== exp_rot.ren)
                    begin
                        $error("renormalized: expected %0b, got %0b", exp_rot.ren, got.ren);
                        bad = 1;
                    end
                    fail_count <= fail_count + bad;
                end
            end
        end
    end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    localparam int LATENCY   = 33;
    localparam int N_RANDOM  = 1600;
    localparam int IDLE_MAX  = 4000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   renorm_seen;
    int   mats_seen;
    int   idle_cycles;
    logic inputs_done;
    logic out_taken;
    int   sink_wait;

    qrm_in_if  quat();
    qrm_out_if matrix();

    quaternion_to_rotation_matrix u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .quat   (quat),
        .matrix (matrix)
    );

    qrm_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .quat        (quat),
        .matrix      (matrix),
        .fail_count  (fail_count),
        .pending     (pending),
        .renorm_seen (renorm_seen),
        .mats_seen   (mats_seen)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [qrm_pkg::IO_W-1:0] rand_elem();
        int mode;
        mode = $urandom_range(9);
        if (mode < 5)
            return qrm_pkg::IO_W'($signed($urandom_range(1400000)) - 700000);
        if (mode < 7)
            return qrm_pkg::IO_W'($signed($urandom_range(2097152)) - 1048576);
        if (mode == 7)
        begin
            unique case ($urandom_range(5))
                0: return 24'h100000;
                1: return 24'hF00000;
                2: return 24'h7FFFFF;
                3: return 24'h800000;
                4: return 24'h000000;
                default: return 24'h100001;
            endcase
        end
        return qrm_pkg::IO_W'($urandom);
    endfunction

    // valid stays high between back-to-back items; dropped only for a gap
    task automatic send_quat(logic [qrm_pkg::IO_W-1:0] x, logic [qrm_pkg::IO_W-1:0] y,
                             logic [qrm_pkg::IO_W-1:0] z);
        int gap;
        gap = ($urandom_range(3) == 0) ? $urandom_range(17) : 0;
        if (gap > 0)
        begin
            quat.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        quat.valid    <= 1'b1;
        quat.q_first  <= x;
        quat.q_second <= y;
        quat.q_third  <= z;
        @(posedge clk);
        while (!quat.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    always @(posedge clk)
        out_taken <= matrix.valid && matrix.ready;

    // sink wait drawn per item, mostly none
    always @(negedge clk or negedge rst_n)
    begin
        int w;
        if (!rst_n)
        begin
            matrix.ready <= 1'b0;
            sink_wait    <= 0;
        end
        else if (out_taken)
        begin
            w = ($urandom_range(3) == 0) ? $urandom_range(17) : 0;
            matrix.ready <= (w == 0);
            sink_wait    <= (w > 0) ? w - 1 : 0;
        end
        else if (sink_wait > 0)
        begin
            matrix.ready <= 1'b0;
            sink_wait    <= sink_wait - 1;
        end
        else
            matrix.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (quat.valid && quat.ready) || (matrix.valid && matrix.ready))
            idle_cycles <= 0;
        else if (inputs_done === 1'b0 || pending > 0)
            idle_cycles <= idle_cycles + 1;
    end

    always @(posedge clk)
        if (idle_cycles >= IDLE_MAX)
        begin
            $display("watchdog: no progress for %0d cycles", IDLE_MAX);
            $display("*** FAILED ***");
            $finish;
        end

    initial
    begin
        logic [qrm_pkg::IO_W-1:0] corner[8];
        corner = '{24'h000000, 24'h100000, 24'hF00000, 24'h7FFFFF, 24'h800000,
                   24'h100001, 24'hEFFFFF, 24'h0B504F};
        inputs_done   = 1'b0;
        rst_n         = 1'b0;
        quat.valid    = 1'b0;
        quat.q_first  = '0;
        quat.q_second = '0;
        quat.q_third  = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // identity, axis extremes, wrap edges, exactly unit, above unit
        foreach (corner[i])
            send_quat(corner[i], 24'h0, 24'h0);
        send_quat(24'h0, 24'h100000, 24'h0);
        send_quat(24'h0, 24'h0, 24'hF00000);
        send_quat(24'h0B504F, 24'h0B504F, 24'h0);
        send_quat(24'h093CD4, 24'h093CD4, 24'h093CD4);
        send_quat(24'h100000, 24'h100000, 24'h100000);
        send_quat(24'h7FFFFF, 24'h800000, 24'h7FFFFF);
        send_quat(24'h080000, 24'hF80000, 24'h080000);
        send_quat(24'h0A0000, 24'h0A0000, 24'h0A0000);
        quat.valid <= 1'b0;

        // drain before carrying on
        while (pending > 0)
            @(negedge clk);

        for (int n = 0; n < N_RANDOM; n++)
            send_quat(rand_elem(), rand_elem(), rand_elem());
        quat.valid <= 1'b0;

        inputs_done = 1'b1;
        while (pending > 0)
            @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);

        $display("Sent %0d quaternions (corners, wrap and unit-sum cases, random); %0d matrices",
                 N_RANDOM + 16, mats_seen);
        $display("checked, %0d of them renormalised.", renorm_seen);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/qrm_pkg.sv
rtl/core/qrm_in_if.sv
rtl/core/qrm_out_if.sv
rtl/core/qrm_front.sv
rtl/core/qrm_iter.sv
rtl/core/qrm_back.sv
rtl/core/quaternion_to_rotation_matrix.sv
sim/qrm_checker.sv
sim/tb_top.sv
